// ===== design/vcaa_pkg.sv =====
// ---------------------------------------------------------------------------
// vcaa_pkg
// shared codes and interface structs of the vc admission allocator
// ---------------------------------------------------------------------------
`default_nettype none

package vcaa_pkg;

  localparam int NODE_W = 4;
  localparam int LEN_W  = 5;
  localparam int FBW_W  = 16;
  localparam int VC_W   = 16;

  localparam logic [1:0] KIND_NH  = 2'd0;
  localparam logic [1:0] KIND_ALT = 2'd1;
  localparam logic [1:0] KIND_CAP = 2'd2;
  localparam logic [1:0] KIND_REQ = 2'd3;

  localparam logic [1:0] ST_LOADED = 2'd0;
  localparam logic [1:0] ST_SP     = 2'd1;
  localparam logic [1:0] ST_ALT    = 2'd2;
  localparam logic [1:0] ST_REJ    = 2'd3;

  typedef struct packed {
    logic              nh_we;
    logic              alt_we;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [NODE_W-1:0] hop;
    logic [NODE_W-1:0] val;
    logic [LEN_W-1:0]  len;
  } route_cmd_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] from_n;
    logic [NODE_W-1:0] to_n;
  } link_cmd_t;

endpackage

`default_nettype wire

// ===== design/vcaa_route_mem.sv =====
// ---------------------------------------------------------------------------
// vcaa_route_mem
// next-hop table, second-route node lists and second-route lengths
// ---------------------------------------------------------------------------
`default_nettype none

module vcaa_route_mem
  import vcaa_pkg::*;
#(
  parameter int NODES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire route_cmd_t        cmd,
  output logic [NODE_W-1:0]      nh_q,
  output logic [NODE_W-1:0]      alt_q,
  output logic [LEN_W-1:0]       len_q
);

  localparam int NB    = (NODES > 16) ? 4 : $clog2(NODES);
  localparam int DEPTH = 1 << (2 * NB);

  logic [NODE_W-1:0] nh_mem  [DEPTH];
  logic [NODE_W-1:0] alt_mem [DEPTH * 16];
  logic [LEN_W-1:0]  len_mem [DEPTH];
  logic [DEPTH-1:0]  len_vld_r;

  logic [2*NB-1:0]   pair;
  logic [2*NB+3:0]   alt_addr;

  assign pair     = {cmd.src[NB-1:0], cmd.dst[NB-1:0]};
  assign alt_addr = {pair, cmd.hop};

  always_ff @(posedge clk) begin
    if (cmd.nh_we) begin
      nh_mem[pair] <= cmd.val;
    end
    if (cmd.alt_we) begin
      alt_mem[alt_addr] <= cmd.val;
      len_mem[pair]     <= cmd.len;
    end
    nh_q  <= nh_mem[pair];
    alt_q <= alt_mem[alt_addr];
    len_q <= len_vld_r[pair] ? len_mem[pair] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_vld_r <= '0;
    end else if (cmd.alt_we) begin
      len_vld_r[pair] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/vcaa_link_mem.sv =====
// ---------------------------------------------------------------------------
// vcaa_link_mem
// per-link capacity and vc counter, zero until first written
// ---------------------------------------------------------------------------
`default_nettype none

module vcaa_link_mem
  import vcaa_pkg::*;
#(
  parameter int NODES   = 16,
  parameter int BW_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire link_cmd_t          cmd,
  input  wire logic [BW_BITS-1:0] wcap,
  input  wire logic [VC_W-1:0]    wcnt,
  output logic [BW_BITS-1:0]      rcap,
  output logic [VC_W-1:0]         rcnt
);

  localparam int NB    = (NODES > 16) ? 4 : $clog2(NODES);
  localparam int DEPTH = 1 << (2 * NB);

  logic [BW_BITS-1:0] cap_mem [DEPTH];
  logic [VC_W-1:0]    cnt_mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [2*NB-1:0]    addr;

  assign addr = {cmd.from_n[NB-1:0], cmd.to_n[NB-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      cap_mem[addr] <= wcap;
      cnt_mem[addr] <= wcnt;
    end
    rcap <= vld_r[addr] ? cap_mem[addr] : '0;
    rcnt <= vld_r[addr] ? cnt_mem[addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.we) begin
      vld_r[addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== design/vcaa_ctrl.sv =====
// ---------------------------------------------------------------------------
// vcaa_ctrl
// sequencer: decode, route walk, second-route check, fit check and commit
// ---------------------------------------------------------------------------
`default_nettype none

module vcaa_ctrl
  import vcaa_pkg::*;
#(
  parameter int NODES   = 16,
  parameter int BW_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [NODE_W-1:0]  in_src_node,
  input  wire logic [NODE_W-1:0]  in_dst_node,
  input  wire logic [NODE_W-1:0]  in_hop_index,
  input  wire logic [NODE_W-1:0]  in_node_value,
  input  wire logic [LEN_W-1:0]   in_path_length,
  input  wire logic [FBW_W-1:0]   in_capacity_value,
  input  wire logic [FBW_W-1:0]   in_bw_max,
  input  wire logic [FBW_W-1:0]   in_bw_min,
  input  wire logic [FBW_W-1:0]   in_bw_avg,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [NODE_W-1:0]       out_from_node,
  output logic [NODE_W-1:0]       out_to_node,
  output logic [VC_W-1:0]         out_vcid,
  output logic                    out_last,
  output route_cmd_t              rcmd,
  input  wire logic [NODE_W-1:0]  nh_q,
  input  wire logic [NODE_W-1:0]  alt_q,
  input  wire logic [LEN_W-1:0]   len_q,
  output link_cmd_t               lcmd,
  output logic [BW_BITS-1:0]      wcap,
  output logic [VC_W-1:0]         wcnt,
  input  wire logic [BW_BITS-1:0] rcap,
  input  wire logic [VC_W-1:0]    rcnt
);

  localparam int CMPW = (BW_BITS > 16) ? BW_BITS : 16;
  localparam logic [NODE_W-1:0] HOP_LIMIT =
    NODE_W'(((NODES - 1) < 15) ? (NODES - 1) : 15);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_EMIT, S_SP, S_SP_CHK, S_ALT_LEN, S_ALT_LCHK,
    S_ALT_RD, S_ALT_CHK, S_FIT_RD, S_FIT_CHK, S_CM_RD, S_CM_WR
  } state_t;

  state_t             state_r;
  logic               pess_r;
  logic [1:0]         kind_r;
  logic [NODE_W-1:0]  src_r, dst_r, hop_r, val_r;
  logic [LEN_W-1:0]   plen_r;
  logic [FBW_W-1:0]   capv_r, bmax_r, bmin_r, bavg_r;
  logic [FBW_W-1:0]   beq_r;
  logic [NODE_W-1:0]  path_r [16];
  logic [NODE_W-1:0]  h_r, i_r, k_r, cur_r, to_r;
  logic [LEN_W-1:0]   len_r;
  logic [15:0]        seen_r;
  logic               route2_r;
  logic [1:0]         res_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [NODE_W-1:0]  out_from_r, out_to_r;
  logic [VC_W-1:0]    out_vcid_r;
  logic               out_last_r;

  logic               out_free, range_ok, val_ok;
  logic [NODE_W-1:0]  pth_nx;
  logic [18:0]        bsum;
  logic [FBW_W:0]     bq;
  logic [FBW_W-1:0]   beq_calc;
  logic [CMPW-1:0]    cap_ext, beq_ext, debit;
  logic               cap_short;

  function automatic logic node_bad(input logic [NODE_W-1:0] n);
    return 7'(n) >= 7'(NODES);
  endfunction

  assign out_free = !out_valid_r || !out_stall;
  assign range_ok = !node_bad(src_r) && !node_bad(dst_r);
  assign val_ok   = !node_bad(val_r);
  assign pth_nx   = path_r[i_r + 4'd1];

  // equivalent bandwidth
  always_comb begin
    bsum = {1'b0, bavg_r, 2'b00} + 19'(bmax_r);
    bq   = (bsum < 19'(bmin_r)) ? '0 : (FBW_W+1)'((bsum - 19'(bmin_r)) >> 2);
    if (pess_r) begin
      beq_calc = bmax_r;
    end else begin
      beq_calc = (bq < {1'b0, bmax_r}) ? bq[FBW_W-1:0] : bmax_r;
    end
  end

  assign cap_ext   = CMPW'(rcap);
  assign beq_ext   = CMPW'(beq_r);
  assign cap_short = cap_ext < beq_ext;
  assign debit     = (cap_ext > beq_ext) ? (cap_ext - beq_ext) : '0;

  always_comb begin
    rcmd.src    = (state_r == S_SP) ? k_r : src_r;
    rcmd.dst    = dst_r;
    rcmd.hop    = (state_r == S_DISP) ? hop_r : i_r;
    rcmd.val    = val_r;
    rcmd.len    = plen_r;
    rcmd.nh_we  = (state_r == S_DISP) && range_ok && val_ok && (kind_r == KIND_NH);
    rcmd.alt_we = (state_r == S_DISP) && range_ok && val_ok && (kind_r == KIND_ALT);

    lcmd.from_n = (state_r == S_DISP) ? src_r : cur_r;
    lcmd.to_n   = (state_r == S_DISP) ? dst_r : ((state_r == S_CM_WR) ? to_r : pth_nx);
    lcmd.we     = ((state_r == S_DISP) && range_ok && (kind_r == KIND_CAP)) ||
                  ((state_r == S_CM_WR) && out_free);
    wcap        = (state_r == S_DISP) ? BW_BITS'(CMPW'(capv_r)) : BW_BITS'(debit);
    wcnt        = (state_r == S_DISP) ? '0 : rcnt + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pess_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        pess_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            src_r   <= in_src_node;
            dst_r   <= in_dst_node;
            hop_r   <= in_hop_index;
            val_r   <= in_node_value;
            plen_r  <= in_path_length;
            capv_r  <= in_capacity_value;
            bmax_r  <= in_bw_max;
            bmin_r  <= in_bw_min;
            bavg_r  <= in_bw_avg;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          res_r   <= ST_LOADED;
          state_r <= S_EMIT;
          if (!range_ok) begin
            res_r <= ST_REJ;
          end else begin
            case (kind_r)
              KIND_NH, KIND_ALT: begin
                if (!val_ok) begin
                  res_r <= ST_REJ;
                end
              end
              KIND_REQ: begin
                if (src_r == dst_r) begin
                  res_r <= ST_REJ;
                end else begin
                  beq_r     <= beq_calc;
                  k_r       <= src_r;
                  h_r       <= '0;
                  path_r[0] <= src_r;
                  route2_r  <= 1'b0;
                  state_r   <= S_SP;
                end
              end
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_r;
            out_from_r   <= src_r;
            out_to_r     <= dst_r;
            out_vcid_r   <= '0;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_SP: begin
          if (k_r == dst_r) begin
            i_r     <= '0;
            cur_r   <= src_r;
            state_r <= S_FIT_RD;
          end else if (h_r >= HOP_LIMIT) begin
            state_r <= S_ALT_LEN;
          end else begin
            state_r <= S_SP_CHK;
          end
        end
        S_SP_CHK: begin
          if (node_bad(nh_q)) begin
            state_r <= S_ALT_LEN;
          end else begin
            path_r[h_r + 4'd1] <= nh_q;
            h_r     <= h_r + 4'd1;
            k_r     <= nh_q;
            state_r <= S_SP;
          end
        end
        S_ALT_LEN: begin
          state_r <= S_ALT_LCHK;
        end
        S_ALT_LCHK: begin
          if (len_q < 5'd2 || len_q > 5'd16) begin
            res_r   <= ST_REJ;
            state_r <= S_EMIT;
          end else begin
            len_r     <= len_q;
            i_r       <= 4'd1;
            seen_r    <= 16'(1) << src_r;
            path_r[0] <= src_r;
            route2_r  <= 1'b1;
            state_r   <= S_ALT_RD;
          end
        end
        S_ALT_RD: begin
          state_r <= S_ALT_CHK;
        end
        S_ALT_CHK: begin
          if (node_bad(alt_q) || seen_r[alt_q]) begin
            res_r   <= ST_REJ;
            state_r <= S_EMIT;
          end else begin
            path_r[i_r] <= alt_q;
            seen_r[alt_q] <= 1'b1;
            if ({1'b0, i_r} == len_r - 5'd1) begin
              if (alt_q == dst_r) begin
                h_r     <= i_r;
                i_r     <= '0;
                cur_r   <= src_r;
                state_r <= S_FIT_RD;
              end else begin
                res_r   <= ST_REJ;
                state_r <= S_EMIT;
              end
            end else begin
              i_r     <= i_r + 4'd1;
              state_r <= S_ALT_RD;
            end
          end
        end
        S_FIT_RD: begin
          to_r    <= pth_nx;
          state_r <= S_FIT_CHK;
        end
        S_FIT_CHK: begin
          if (cap_short) begin
            if (route2_r) begin
              res_r   <= ST_REJ;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_ALT_LEN;
            end
          end else if (i_r == h_r - 4'd1) begin
            i_r     <= '0;
            cur_r   <= src_r;
            state_r <= S_CM_RD;
          end else begin
            i_r     <= i_r + 4'd1;
            cur_r   <= to_r;
            state_r <= S_FIT_RD;
          end
        end
        S_CM_RD: begin
          to_r    <= pth_nx;
          state_r <= S_CM_WR;
        end
        S_CM_WR: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= route2_r ? ST_ALT : ST_SP;
            out_from_r   <= cur_r;
            out_to_r     <= to_r;
            out_vcid_r   <= rcnt;
            out_last_r   <= (i_r == h_r - 4'd1);
            if (i_r == h_r - 4'd1) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 4'd1;
              cur_r   <= to_r;
              state_r <= S_CM_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_from_node = out_from_r;
  assign out_to_node   = out_to_r;
  assign out_vcid      = out_vcid_r;
  assign out_last      = out_last_r;

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_DISP))
    else $error("accepted transfer not decoded");

  a_commit_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CM_WR && out_free) |=> out_valid_r)
    else $error("commit without result");

  a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SP) |-> (h_r <= HOP_LIMIT))
    else $error("route walk beyond hop limit");

  a_alt_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALT_CHK) |-> (i_r != 4'd0))
    else $error("second route reads source slot");

  a_link_write: assert property (@(posedge clk) disable iff (!rst_n)
    lcmd.we |-> (state_r == S_DISP || state_r == S_CM_WR))
    else $error("link write outside load or commit");

endmodule

`default_nettype wire

// ===== design/vc_admission_allocator.sv =====
// ---------------------------------------------------------------------------
// vc_admission_allocator
// virtual-circuit admission with equivalent bandwidth on two routes
//
// Input channel in_*: one transfer per item (table load or connection
// request). Output channel out_*: one transfer per result; a request that
// is admitted gives one result per link, else a single result with status.
// cfg_we/cfg_wdata set the pessimistic mode; the user writes them only while
// the block is idle, which the block does not enforce. One item is processed
// at a time; in_stall is high from acceptance until the last result is
// registered. A load passes decode and emit, and the next item is taken once
// the sequencer is idle again. A request walks its route through the
// next-hop table, a read and a check per hop; if the walk or the first-route
// fit check fails, it reads the second-route length and then each entry of
// the second route. The fit check and the commit take a read and a check or
// write per link through the single read port of the link and route
// memories. Reset clears the sequencer, the output valid bit and the valid
// bits that make lengths, capacities and vc counters read as zero. A stall
// on the output holds the result register and the emit and commit states.
// ---------------------------------------------------------------------------
`default_nettype none

module vc_admission_allocator
  import vcaa_pkg::*;
#(
  parameter int NODES   = 16,
  parameter int BW_BITS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_kind,
  input  wire logic [NODE_W-1:0] in_src_node,
  input  wire logic [NODE_W-1:0] in_dst_node,
  input  wire logic [NODE_W-1:0] in_hop_index,
  input  wire logic [NODE_W-1:0] in_node_value,
  input  wire logic [LEN_W-1:0]  in_path_length,
  input  wire logic [FBW_W-1:0]  in_capacity_value,
  input  wire logic [FBW_W-1:0]  in_bw_max,
  input  wire logic [FBW_W-1:0]  in_bw_min,
  input  wire logic [FBW_W-1:0]  in_bw_avg,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_status,
  output logic [NODE_W-1:0]      out_from_node,
  output logic [NODE_W-1:0]      out_to_node,
  output logic [VC_W-1:0]        out_vcid,
  output logic                   out_last
);

  route_cmd_t         rcmd;
  link_cmd_t          lcmd;
  logic [NODE_W-1:0]  nh_q, alt_q;
  logic [LEN_W-1:0]   len_q;
  logic [BW_BITS-1:0] wcap, rcap;
  logic [VC_W-1:0]    wcnt, rcnt;

  vcaa_ctrl #(.NODES(NODES), .BW_BITS(BW_BITS)) u_ctrl (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .in_kind, .in_src_node, .in_dst_node,
    .in_hop_index, .in_node_value, .in_path_length, .in_capacity_value,
    .in_bw_max, .in_bw_min, .in_bw_avg,
    .out_valid, .out_stall, .out_status, .out_from_node, .out_to_node,
    .out_vcid, .out_last,
    .rcmd, .nh_q, .alt_q, .len_q,
    .lcmd, .wcap, .wcnt, .rcap, .rcnt
  );

  vcaa_route_mem #(.NODES(NODES)) u_route_mem (
    .clk, .rst_n, .cmd(rcmd), .nh_q, .alt_q, .len_q
  );

  vcaa_link_mem #(.NODES(NODES), .BW_BITS(BW_BITS)) u_link_mem (
    .clk, .rst_n, .cmd(lcmd), .wcap, .wcnt, .rcap, .rcnt
  );

endmodule

`default_nettype wire
